FILE: src/can_message_cache_core_defines.svh
// Assertion macros shared by the checker of can_message_cache_core.
`ifndef CAN_MESSAGE_CACHE_CORE_DEFINES_SVH
`define CAN_MESSAGE_CACHE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define CMC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("can_message_cache_core: check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define CMC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("can_message_cache_core: check failed");

`endif

FILE: src/cmc_pkg.sv
// Shared types and constants of the CAN message cache.
package cmc_pkg;

  localparam int unsigned ENTRIES_DEF = 64;

  localparam logic [7:0] FAIL_LIMIT_RST = 8'd3;
  localparam logic [7:0] FAIL_MAX       = 8'hFF;

  localparam logic [1:0] MODE_FRAME   = 2'd0;
  localparam logic [1:0] MODE_QUERY   = 2'd1;
  localparam logic [1:0] MODE_TIMEOUT = 2'd2;

  localparam logic [2:0] ST_DONE   = 3'd0;
  localparam logic [2:0] ST_CACHED = 3'd1;
  localparam logic [2:0] ST_FAIL   = 3'd2;
  localparam logic [2:0] ST_ASK    = 3'd3;
  localparam logic [2:0] ST_FULL   = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [28:0] can_id;
    logic        is_remote;
    logic [3:0]  frame_length;
    logic [63:0] frame_data;
    logic [31:0] now_time;
  } item_t;

  // Token handed from cell to cell along the chain.
  typedef struct packed {
    logic        active;
    logic        hit;
    logic        created;
    logic        valid;
    logic [7:0]  fail;
    logic [3:0]  len;
    logic [63:0] data;
    logic [31:0] stamp;
  } link_t;

endpackage

FILE: src/cmc_cell.sv
// One cache entry of the chain: compare, update and pass the token on.
module cmc_cell #(
  parameter int unsigned         IDX_W    = 7,
  parameter logic [IDX_W-1:0]    CELL_IDX = '0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmc_pkg::item_t    item_i,
  input  logic [IDX_W-1:0]  used_i,
  input  cmc_pkg::link_t    link_i,
  output cmc_pkg::link_t    link_o
);

  logic [28:0] ident_q, ident_d;
  logic [63:0] bytes_q, bytes_d;
  logic [3:0]  len_q, len_d;
  logic        valid_q, valid_d;
  logic [7:0]  fail_q, fail_d;
  logic [31:0] stamp_q, stamp_d;
  cmc_pkg::link_t link_q, link_d;

  logic take, hit, create;

  always_comb begin
    take   = link_i.active && !link_i.hit && !link_i.created;
    hit    = take && (CELL_IDX < used_i) && (ident_q == item_i.can_id);
    create = take && (CELL_IDX == used_i) && (item_i.mode == cmc_pkg::MODE_TIMEOUT);

    ident_d = ident_q;
    bytes_d = bytes_q;
    len_d   = len_q;
    valid_d = valid_q;
    fail_d  = fail_q;
    stamp_d = stamp_q;

    if (hit && item_i.mode == cmc_pkg::MODE_FRAME && !item_i.is_remote) begin
      bytes_d = item_i.frame_data;
      len_d   = item_i.frame_length;
      valid_d = 1'b1;
      fail_d  = 8'd0;
      stamp_d = item_i.now_time;
    end
    if ((hit && item_i.mode == cmc_pkg::MODE_TIMEOUT) || create) begin
      bytes_d = '0;
      len_d   = '0;
      valid_d = 1'b0;
      stamp_d = '0;
      if (create) begin
        ident_d = item_i.can_id;
        fail_d  = 8'd1;
      end else if (fail_q != cmc_pkg::FAIL_MAX) begin
        fail_d = fail_q + 8'd1;
      end
    end

    link_d = link_i;
    if (hit) begin
      link_d.hit   = 1'b1;
      link_d.valid = valid_q;
      link_d.fail  = fail_q;
      link_d.len   = len_q;
      link_d.data  = bytes_q;
      link_d.stamp = stamp_q;
    end
    if (create) begin
      link_d.created = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    ident_q <= ident_d;
    bytes_q <= bytes_d;
    len_q   <= len_d;
    valid_q <= valid_d;
    fail_q  <= fail_d;
    stamp_q <= stamp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= '0;
    end else begin
      link_q <= link_d;
    end
  end

  assign link_o = link_q;

endmodule

FILE: src/can_message_cache_core.sv
// CAN frame cache keyed by identifier, built as a chain of entry cells.
//
// Usage:
//   Command channel: an item (mode, id, frame fields, time) is taken at a
//   clock edge with start high and busy low. busy stays high while the
//   item's token walks the cell chain.
//   Result channel: one result per item, shown for exactly one cycle with
//   result_strobe_o high. The receiver cannot stall; take it that cycle.
//   Config channel: cfg_valid_i/cfg_ready_o with cfg_data_i writes the
//   fail limit; write only while no transaction is in flight.
// Timing:
//   The token moves one cell per cycle through ENTRIES cells; the result
//   strobe follows once the token leaves the last cell, and a new item
//   can be taken in the strobe cycle.
// Reset:
//   Clears the entry count, control state and sets the fail limit to 3.
//   Entry contents are not cleared; only entries below the count are used.
module can_message_cache_core #(
  parameter int unsigned ENTRIES = cmc_pkg::ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [28:0] can_id_i,
  input  logic        is_remote_i,
  input  logic [3:0]  frame_length_i,
  input  logic [63:0] frame_data_i,
  input  logic [31:0] now_time_i,
  output logic        result_strobe_o,
  output logic [2:0]  status_o,
  output logic [3:0]  reply_length_o,
  output logic [63:0] reply_data_o,
  output logic [31:0] reply_time_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(ENTRIES + 1);

  cmc_pkg::state_e state_q, state_d;
  cmc_pkg::item_t  item_q;
  cmc_pkg::link_t  links [ENTRIES+1];
  cmc_pkg::link_t  tail;

  logic             inject_q, inject_d;
  logic [7:0]       fail_limit_q;
  logic [IDX_W-1:0] used_q, used_d;
  logic [2:0]       status_q, status_d;
  logic [3:0]       rlen_q, rlen_d;
  logic [63:0]      rdata_q, rdata_d;
  logic [31:0]      rtime_q, rtime_d;
  logic             accept;
  logic [7:0]       seen_fail;

  assign busy        = (state_q == cmc_pkg::S_SCAN);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign tail        = links[ENTRIES];

  always_comb begin
    links[0]        = '0;
    links[0].active = inject_q;
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    cmc_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (IDX_W'(g))
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .item_i (item_q),
      .used_i (used_q),
      .link_i (links[g]),
      .link_o (links[g+1])
    );
  end

  always_comb begin
    state_d   = state_q;
    inject_d  = 1'b0;
    used_d    = used_q;
    status_d  = status_q;
    rlen_d    = rlen_q;
    rdata_d   = rdata_q;
    rtime_d   = rtime_q;
    seen_fail = tail.hit ? tail.fail : 8'd0;

    case (state_q)
      cmc_pkg::S_IDLE, cmc_pkg::S_RESP: begin
        if (accept) begin
          state_d  = cmc_pkg::S_SCAN;
          inject_d = 1'b1;
        end else begin
          state_d = cmc_pkg::S_IDLE;
        end
      end
      cmc_pkg::S_SCAN: begin
        if (tail.active) begin
          state_d  = cmc_pkg::S_RESP;
          status_d = cmc_pkg::ST_DONE;
          rlen_d   = '0;
          rdata_d  = '0;
          rtime_d  = '0;
          if (tail.created) begin
            used_d = used_q + IDX_W'(1);
          end
          case (item_q.mode)
            cmc_pkg::MODE_QUERY: begin
              if (tail.hit && tail.valid) begin
                status_d = cmc_pkg::ST_CACHED;
                rlen_d   = tail.len;
                rdata_d  = tail.data;
                rtime_d  = tail.stamp;
              end else if (seen_fail >= fail_limit_q) begin
                status_d = cmc_pkg::ST_FAIL;
              end else begin
                status_d = cmc_pkg::ST_ASK;
              end
            end
            cmc_pkg::MODE_TIMEOUT: begin
              if (!tail.hit && !tail.created) begin
                status_d = cmc_pkg::ST_FULL;
              end
            end
            default: status_d = cmc_pkg::ST_DONE;
          endcase
        end
      end
      default: state_d = cmc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= cmc_pkg::S_IDLE;
      inject_q     <= 1'b0;
      used_q       <= '0;
      fail_limit_q <= cmc_pkg::FAIL_LIMIT_RST;
    end else begin
      state_q  <= state_d;
      inject_q <= inject_d;
      used_q   <= used_d;
      if (cfg_valid_i && cfg_ready_o) begin
        fail_limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.mode         <= mode_i;
      item_q.can_id       <= can_id_i;
      item_q.is_remote    <= is_remote_i;
      item_q.frame_length <= frame_length_i;
      item_q.frame_data   <= frame_data_i;
      item_q.now_time     <= now_time_i;
    end
    status_q <= status_d;
    rlen_q   <= rlen_d;
    rdata_q  <= rdata_d;
    rtime_q  <= rtime_d;
  end

  assign result_strobe_o = (state_q == cmc_pkg::S_RESP);
  assign status_o        = status_q;
  assign reply_length_o  = rlen_q;
  assign reply_data_o    = rdata_q;
  assign reply_time_o    = rtime_q;

endmodule

FILE: src/cmc_checker.sv
// Port-level checks of can_message_cache_core, bound to the top level.
`include "can_message_cache_core_defines.svh"

module cmc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        result_strobe_o,
  input logic [2:0]  status_o,
  input logic [3:0]  reply_length_o,
  input logic [63:0] reply_data_o,
  input logic [31:0] reply_time_o
);

  `CMC_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `CMC_ASSERT_NOW(a_strobe_after_busy, result_strobe_o, $past(busy))
  `CMC_ASSERT_NOW(a_busy_ends_with_result, $fell(busy), result_strobe_o)
  `CMC_ASSERT_NOW(a_status_range, result_strobe_o, status_o <= cmc_pkg::ST_FULL)
  `CMC_ASSERT_NOW(a_reply_zero, result_strobe_o && status_o != cmc_pkg::ST_CACHED, reply_length_o == '0 && reply_data_o == '0 && reply_time_o == '0)

endmodule

bind can_message_cache_core cmc_checker u_cmc_checker (.*);

FILE: tb/tb.sv
// Self-checking testbench for can_message_cache_core: directed and random cache traffic.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cmc_pkg::*;

  localparam int unsigned DEPTH = ENTRIES_DEF;
  localparam int unsigned POOL_N = DEPTH + 8;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned REPORT_MAX = 10;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  len;
    logic [63:0] data;
    logic [31:0] stamp;
  } reply_t;

  typedef struct packed {
    logic       is_cfg;
    logic       quiet;
    logic [7:0] limit;
    item_t      cmd;
  } op_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  item_t       cmd_q = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i = FAIL_LIMIT_RST;
  logic        result_strobe_o;
  logic [2:0]  status_o;
  logic [3:0]  reply_length_o;
  logic [63:0] reply_data_o;
  logic [31:0] reply_time_o;

  op_t         pending_ops[$];
  reply_t      replies_due[$];
  logic [28:0] id_pool[POOL_N];
  int unsigned gap_left = 0;
  int unsigned n_taken = 0;
  int unsigned n_answered = 0;
  int unsigned stall_cycles = 0;
  int unsigned mismatches = 0;

  // Mirror of the cache contents
  logic [28:0] m_ident[DEPTH];
  logic [63:0] m_bytes[DEPTH];
  logic [3:0]  m_len[DEPTH];
  logic        m_valid[DEPTH];
  logic [7:0]  m_fails[DEPTH];
  logic [31:0] m_stamp[DEPTH];
  int unsigned m_used = 0;
  logic [7:0]  m_limit = FAIL_LIMIT_RST;

  can_message_cache_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (cmd_q.mode),
    .can_id_i       (cmd_q.can_id),
    .is_remote_i    (cmd_q.is_remote),
    .frame_length_i (cmd_q.frame_length),
    .frame_data_i   (cmd_q.frame_data),
    .now_time_i     (cmd_q.now_time),
    .result_strobe_o(result_strobe_o),
    .status_o       (status_o),
    .reply_length_o (reply_length_o),
    .reply_data_o   (reply_data_o),
    .reply_time_o   (reply_time_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  initial forever #1 clk_i = ~clk_i;

  function automatic reply_t cache_apply(item_t it);
    reply_t     r;
    int         slot;
    logic [7:0] fails_now;
    r = '0;
    slot = -1;
    fails_now = 8'd0;
    for (int i = 0; i < int'(m_used); i++) begin
      if (slot < 0 && m_ident[i] == it.can_id) slot = i;
    end
    if (slot >= 0) fails_now = m_fails[slot];
    case (it.mode)
      MODE_FRAME: begin
        if (!it.is_remote && slot >= 0) begin
          m_bytes[slot] = it.frame_data;
          m_len[slot] = it.frame_length;
          m_valid[slot] = 1'b1;
          m_fails[slot] = 8'd0;
          m_stamp[slot] = it.now_time;
        end
      end
      MODE_QUERY: begin
        if (slot >= 0 && m_valid[slot]) begin
          r.status = ST_CACHED;
          r.len = m_len[slot];
          r.data = m_bytes[slot];
          r.stamp = m_stamp[slot];
        end else if (fails_now >= m_limit) begin
          r.status = ST_FAIL;
        end else begin
          r.status = ST_ASK;
        end
      end
      MODE_TIMEOUT: begin
        if (slot >= 0) begin
          if (m_fails[slot] != FAIL_MAX) m_fails[slot] = m_fails[slot] + 8'd1;
        end else if (m_used >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          slot = m_used;
          m_used++;
          m_ident[slot] = it.can_id;
          m_fails[slot] = 8'd1;
        end
        if (r.status == ST_DONE) begin
          m_bytes[slot] = '0;
          m_len[slot] = '0;
          m_valid[slot] = 1'b0;
          m_stamp[slot] = '0;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic put(logic [1:0] m, logic [28:0] id, logic rem, logic [3:0] len,
                     logic [63:0] d, logic [31:0] t, logic quiet);
    op_t o;
    o = '0;
    o.quiet = quiet;
    o.cmd.mode = m;
    o.cmd.can_id = id;
    o.cmd.is_remote = rem;
    o.cmd.frame_length = len;
    o.cmd.frame_data = d;
    o.cmd.now_time = t;
    pending_ops.push_back(o);
  endtask

  task automatic put_any(logic [1:0] m, logic [28:0] id, logic quiet);
    logic [3:0] len;
    len = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
    put(m, id, $urandom_range(99) < 15, len, {$urandom(), $urandom()}, $urandom(), quiet);
  endtask

  task automatic put_limit(logic [7:0] v);
    op_t o;
    o = '0;
    o.is_cfg = 1'b1;
    o.limit = v;
    pending_ops.push_back(o);
  endtask

  task automatic put_mix(int n, logic quiet);
    int unsigned roll;
    logic [1:0]  m;
    logic [28:0] id;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(99);
      if (roll < 35) m = MODE_FRAME;
      else if (roll < 65) m = MODE_QUERY;
      else if (roll < 94) m = MODE_TIMEOUT;
      else m = MODE_SPARE;
      id = ($urandom_range(99) < 92) ? id_pool[$urandom_range(POOL_N - 1)]
                                     : 29'($urandom());
      put_any(m, id, quiet);
    end
  endtask

  // Command and config driver
  always @(posedge clk_i or negedge rst_ni) begin : driver
    logic took_item;
    logic holding;
    if (!rst_ni) begin
      start <= 1'b0;
      cfg_valid_i <= 1'b0;
      gap_left <= 0;
      n_taken <= 0;
    end else begin
      took_item = start && !busy;
      if (took_item) begin
        replies_due.push_back(cache_apply(cmd_q));
        n_taken <= n_taken + 1;
      end
      if (cfg_valid_i && cfg_ready_o) m_limit = cfg_data_i;
      holding = (start && busy) || (cfg_valid_i && !cfg_ready_o);
      if (!holding) begin
        if (gap_left != 0) begin
          start <= 1'b0;
          cfg_valid_i <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_ops.size() == 0) begin
          start <= 1'b0;
          cfg_valid_i <= 1'b0;
        end else if (pending_ops[0].is_cfg) begin
          start <= 1'b0;
          // only once every outstanding transaction has returned
          if (!took_item && !busy && n_taken == n_answered) begin
            cfg_valid_i <= 1'b1;
            cfg_data_i <= pending_ops[0].limit;
            void'(pending_ops.pop_front());
          end else begin
            cfg_valid_i <= 1'b0;
          end
        end else if (!pending_ops[0].quiet && $urandom_range(99) < 10) begin
          start <= 1'b0;
          cfg_valid_i <= 1'b0;
          gap_left <= $urandom_range(70);
        end else begin
          start <= 1'b1;
          cfg_valid_i <= 1'b0;
          cmd_q <= pending_ops[0].cmd;
          void'(pending_ops.pop_front());
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    reply_t got;
    reply_t want;
    if (!rst_ni) begin
      n_answered <= 0;
    end else if (result_strobe_o) begin
      got = {status_o, reply_length_o, reply_data_o, reply_time_o};
      n_answered <= n_answered + 1;
      if (replies_due.size() == 0) begin
        if (mismatches < REPORT_MAX)
          $display("unexpected result: status %0d len %0d data %h time %h",
                   got.status, got.len, got.data, got.stamp);
        mismatches++;
      end else begin
        want = replies_due.pop_front();
        if (got.status !== want.status || got.len !== want.len ||
            got.data !== want.data || got.stamp !== want.stamp) begin
          if (mismatches < REPORT_MAX)
            $display("result mismatch: exp status %0d len %0d data %h time %h, got %0d %0d %h %h",
                     want.status, want.len, want.data, want.stamp,
                     got.status, got.len, got.data, got.stamp);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || (cfg_valid_i && cfg_ready_o) || result_strobe_o) begin
        stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    logic [28:0] a;
    logic [28:0] z;
    logic [28:0] hi;
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int i = 2; i < POOL_N; i++) id_pool[i] = 29'($urandom());
    a = id_pool[2];
    z = id_pool[0];
    hi = id_pool[1];

    // directed, fail limit at reset value
    put_any(MODE_QUERY, a, 1'b0);
    put(MODE_FRAME, a, 1'b0, 4'd8, '1, '1, 1'b0);
    put_any(MODE_TIMEOUT, a, 1'b0);
    put_any(MODE_QUERY, a, 1'b0);
    put_any(MODE_TIMEOUT, a, 1'b0);
    put_any(MODE_TIMEOUT, a, 1'b0);
    put_any(MODE_QUERY, a, 1'b0);
    put(MODE_FRAME, a, 1'b1, 4'd8, {$urandom(), $urandom()}, $urandom(), 1'b0);
    put_any(MODE_QUERY, a, 1'b0);
    put(MODE_FRAME, a, 1'b0, 4'd8, '1, '1, 1'b0);
    put_any(MODE_QUERY, a, 1'b0);
    put(MODE_FRAME, a, 1'b0, 4'd15, '0, '0, 1'b0);
    put_any(MODE_QUERY, a, 1'b0);
    put_any(MODE_TIMEOUT, a, 1'b0);
    put_any(MODE_QUERY, a, 1'b0);
    put_any(MODE_SPARE, a, 1'b0);
    put_any(MODE_QUERY, a, 1'b0);
    put_any(MODE_TIMEOUT, z, 1'b0);
    put(MODE_FRAME, z, 1'b0, 4'd0, '0, '0, 1'b0);
    put_any(MODE_QUERY, z, 1'b0);
    put_any(MODE_TIMEOUT, hi, 1'b0);
    put(MODE_FRAME, hi, 1'b0, 4'd9, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555, 1'b0);
    put_any(MODE_QUERY, hi, 1'b0);
    put(MODE_FRAME, hi, 1'b0, 4'd4, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 1'b0);
    put_any(MODE_QUERY, hi, 1'b0);

    // fail count saturation at the top limit, back to back
    put_limit(FAIL_MAX);
    a = id_pool[3];
    put(MODE_FRAME, a, 1'b0, 4'd8, {$urandom(), $urandom()}, $urandom(), 1'b1);
    for (int k = 0; k < 253; k++) put_any(MODE_TIMEOUT, a, 1'b1);
    for (int k = 0; k < 3; k++) begin
      put_any(MODE_QUERY, a, 1'b1);
      put_any(MODE_TIMEOUT, a, 1'b1);
    end
    put_any(MODE_QUERY, a, 1'b1);
    put(MODE_FRAME, a, 1'b0, 4'd3, {$urandom(), $urandom()}, $urandom(), 1'b1);
    put_any(MODE_QUERY, a, 1'b1);

    put_limit(8'd1);
    put_mix(15, 1'b0);
    put_limit(8'($urandom_range(254, 2)));
    put_mix(15, 1'b0);

    // fill the table past capacity, then traffic on a full table
    put_limit(8'($urandom_range(8, 2)));
    for (int i = 0; i < POOL_N; i++) put_any(MODE_TIMEOUT, id_pool[i], 1'b0);
    put_mix(15, 1'b0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i);
    while (pending_ops.size() != 0 || start || cfg_valid_i || n_taken != n_answered);
    repeat (DEPTH + 10) @(posedge clk_i);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
